// ===== design/qrr_pkg.sv =====
// shared constants for the quadratic real roots block
package qrr_pkg;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [1:0] ST_TWO = 2'd0;
  localparam logic [1:0] ST_DOUBLE = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_AZERO = 2'd3;

  localparam int QUEUE_DEPTH = 4;
endpackage

// ===== design/qrr_front.sv =====
// front end: discriminant and classification, one item per cycle
module qrr_front import qrr_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF,
  localparam int DW = 2 * CW + 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic signed [CW-1:0] c,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [DW-1:0]        out_disc,
  output logic signed [CW-1:0] out_a,
  output logic signed [CW-1:0] out_b
);
  // stage 1: products
  logic                 v1;
  logic signed [2*CW:0] bb1, ac1;
  logic signed [CW-1:0] a1, b1;
  logic signed [DW-1:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    bb1 <= (2*CW+1)'(b) * (2*CW+1)'(b);
    ac1 <= (2*CW+1)'(a) * (2*CW+1)'(c);
    a1 <= a;
    b1 <= b;
  end

  assign d = DW'(bb1) - (DW'(ac1) <<< 2);

  always_ff @(posedge clk) begin
    out_a <= a1;
    out_b <= b1;
    out_disc <= d;
    if (a1 == '0) out_status <= ST_AZERO;
    else if (d < 0) out_status <= ST_NONE;
    else if (d == '0) out_status <= ST_DOUBLE;
    else out_status <= ST_TWO;
  end
endmodule

// ===== design/qrr_queue.sv =====
// short fifo between front and back
module qrr_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign not_empty = cnt != '0;
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== design/qrr_back.sv =====
// back end: pipelined square root, two dividers and saturation
module qrr_back import qrr_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF,
  localparam int DW = 2 * CW + 3,
  localparam int SW = CW + 2,
  localparam int NW = CW + 3 + FB,
  localparam int MW = CW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_status,
  input  logic [DW-1:0]        in_disc,
  input  logic signed [CW-1:0] in_a,
  input  logic signed [CW-1:0] in_b,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [CW-1:0]        out_plus,
  output logic [CW-1:0]        out_minus,
  output logic                 out_sat
);
  // square root: one result bit per stage
  logic [SW:0]          sv;
  logic [1:0]           sst [SW+1];
  logic [DW-1:0]        sd  [SW+1];
  logic [SW-1:0]        sr  [SW+1];
  logic [SW+1:0]        srm [SW+1];
  logic signed [CW-1:0] sa  [SW+1];
  logic signed [CW-1:0] sb  [SW+1];

  assign sv[0] = in_valid;
  assign sst[0] = in_status;
  assign sd[0] = (in_status == ST_TWO) ? in_disc : '0;
  assign sr[0] = '0;
  assign srm[0] = '0;
  assign sa[0] = in_a;
  assign sb[0] = in_b;

  // digit recurrence: bring down two discriminant bits, try {root, 01}
  for (genvar i = 0; i < SW; i++) begin : g_sq
    localparam int K = SW - 1 - i;
    logic [2*SW-1:0] dx;
    logic [SW+1:0] tr, tq;
    assign dx = (2*SW)'(sd[i]);
    assign tr = {srm[i][SW-1:0], dx[2*K+1 -: 2]};
    assign tq = {sr[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else sv[i+1] <= sv[i];
      if (tr >= tq) begin
        srm[i+1] <= tr - tq;
        sr[i+1] <= {sr[i][SW-2:0], 1'b1};
      end else begin
        srm[i+1] <= tr;
        sr[i+1] <= {sr[i][SW-2:0], 1'b0};
      end
      sd[i+1] <= sd[i];
      sst[i+1] <= sst[i];
      sa[i+1] <= sa[i];
      sb[i+1] <= sb[i];
    end
  end

  // numerators and denominator magnitude
  logic signed [CW+3:0] nump, numm;
  logic [MW:0] den;
  logic negd;
  assign nump = -(CW+4)'(sb[SW]) + (CW+4)'(signed'({1'b0, sr[SW]}));
  assign numm = -(CW+4)'(sb[SW]) - (CW+4)'(signed'({1'b0, sr[SW]}));
  assign negd = sa[SW][CW-1];
  assign den = negd ? -(MW+1)'(sa[SW]) << 1 : (MW+1)'(sa[SW]) << 1;

  logic [NW:0] np0, nm0;
  assign np0 = nump[CW+3] ? (NW+1)'(-nump) << FB : (NW+1)'(nump) << FB;
  assign nm0 = numm[CW+3] ? (NW+1)'(-numm) << FB : (NW+1)'(numm) << FB;

  // restoring divide, one quotient bit per stage, both roots side by side
  localparam int QN = NW + 1;
  logic [QN:0]   dv;
  logic [1:0]    dst  [QN+1];
  logic [MW:0]   dden [QN+1];
  logic [NW:0]   qp   [QN+1];
  logic [NW:0]   qm   [QN+1];
  logic [MW+1:0] rpm  [QN+1];
  logic [MW+1:0] rmm  [QN+1];
  logic          ngp  [QN+1];
  logic          ngm  [QN+1];

  assign dv[0] = sv[SW];
  assign dst[0] = sst[SW];
  assign dden[0] = den;
  assign qp[0] = np0;
  assign qm[0] = nm0;
  assign rpm[0] = '0;
  assign rmm[0] = '0;
  assign ngp[0] = nump[CW+3] ^ negd;
  assign ngm[0] = numm[CW+3] ^ negd;

  for (genvar j = 0; j < QN; j++) begin : g_dv
    logic [MW+1:0] tp, tm;
    assign tp = {rpm[j][MW:0], qp[j][NW]};
    assign tm = {rmm[j][MW:0], qm[j][NW]};
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else dv[j+1] <= dv[j];
      if (tp >= (MW+2)'(dden[j])) begin
        rpm[j+1] <= tp - (MW+2)'(dden[j]);
        qp[j+1] <= {qp[j][NW-1:0], 1'b1};
      end else begin
        rpm[j+1] <= tp;
        qp[j+1] <= {qp[j][NW-1:0], 1'b0};
      end
      if (tm >= (MW+2)'(dden[j])) begin
        rmm[j+1] <= tm - (MW+2)'(dden[j]);
        qm[j+1] <= {qm[j][NW-1:0], 1'b1};
      end else begin
        rmm[j+1] <= tm;
        qm[j+1] <= {qm[j][NW-1:0], 1'b0};
      end
      dden[j+1] <= dden[j];
      dst[j+1] <= dst[j];
      ngp[j+1] <= ngp[j];
      ngm[j+1] <= ngm[j];
    end
  end

  // saturate and sign
  localparam logic [NW:0] LIMP = (NW+1)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [NW:0] LIMN = (NW+1)'(64'd1 << (CW - 1));
  logic [NW:0] lp, lm, mp, mm;
  logic satp, satm, live;
  assign live = dst[QN] == ST_TWO || dst[QN] == ST_DOUBLE;
  assign lp = ngp[QN] ? LIMN : LIMP;
  assign lm = ngm[QN] ? LIMN : LIMP;
  assign satp = qp[QN] > lp;
  assign satm = qm[QN] > lm;
  assign mp = satp ? lp : qp[QN];
  assign mm = satm ? lm : qm[QN];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv[QN];
    out_status <= dst[QN];
    out_plus <= live ? CW'(ngp[QN] ? -mp : mp) : '0;
    out_minus <= live ? CW'(ngm[QN] ? -mm : mm) : '0;
    out_sat <= live & (satp | satm);
  end
endmodule

// ===== design/quadratic_real_roots_top.sv =====
// top level of the quadratic real roots block
// Usage: drive coef_a, coef_b, coef_c and pulse start while busy is low;
// the beat is taken at that clock edge. One item per cycle is accepted.
// Each item gives one result beat on done, with root_status, root_plus,
// root_minus and saturated valid for that single cycle.
// Each item passes the product and classification registers of the
// front end, the queue, COEF_WIDTH+2 square-root stages,
// COEF_WIDTH+FRACTION_BITS+4 divider stages and one output register.
// The queue is popped in the cycle after each push. The divider
// pipeline holds most of these stages.
// The back end never stalls since the receiver cannot hold results off,
// so busy stays low after reset and the queue never fills.
// Synchronous reset clears all valid bits; no result appears for items
// in flight at reset.
// Coefficients are signed fixed point with FRACTION_BITS fraction bits;
// a zero a gives status 3 with zero roots.
module quadratic_real_roots_top import qrr_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                         done,
  output logic [1:0]                   root_status,
  output logic signed [COEF_WIDTH-1:0] root_plus,
  output logic signed [COEF_WIDTH-1:0] root_minus,
  output logic                         saturated
);
  localparam int DW = 2 * COEF_WIDTH + 3;
  localparam int QW = 2 + DW + 2 * COEF_WIDTH;

  logic fv, qv;
  logic [1:0] fst;
  logic [DW-1:0] fd;
  logic signed [COEF_WIDTH-1:0] fa, fb;
  logic [QW-1:0] qd;
  logic [COEF_WIDTH-1:0] rp, rm;

  assign busy = 1'b0;

  qrr_front #(.CW(COEF_WIDTH)) u_front (
    .clk, .rst, .in_valid(start & ~busy), .a(coef_a), .b(coef_b), .c(coef_c),
    .out_valid(fv), .out_status(fst), .out_disc(fd), .out_a(fa), .out_b(fb)
  );

  qrr_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push(fv), .push_data({fst, fd, fa, fb}),
    .pop(qv), .not_empty(qv), .pop_data(qd)
  );

  qrr_back #(.CW(COEF_WIDTH), .FB(FRACTION_BITS)) u_back (
    .clk, .rst, .in_valid(qv),
    .in_status(qd[QW-1 -: 2]),
    .in_disc(qd[QW-3 -: DW]),
    .in_a(signed'(qd[2*COEF_WIDTH-1 -: COEF_WIDTH])),
    .in_b(signed'(qd[COEF_WIDTH-1:0])),
    .out_valid(done), .out_status(root_status), .out_plus(rp), .out_minus(rm),
    .out_sat(saturated)
  );

  assign root_plus = signed'(rp);
  assign root_minus = signed'(rm);

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_zero_a: assert property (@(posedge clk) disable iff (rst)
    done && root_status == ST_AZERO |-> root_plus == '0 && root_minus == '0)
    else $error("a zero with roots");
  a_none: assert property (@(posedge clk) disable iff (rst)
    done && root_status == ST_NONE |-> !saturated && root_plus == '0)
    else $error("no roots but value");
  a_double: assert property (@(posedge clk) disable iff (rst)
    done && root_status == ST_DOUBLE |-> root_plus == root_minus)
    else $error("double root differs");
`endif
endmodule
